// ----- hw/rtl/bcmp_pkg.sv -----
// Shared types and constants for the binomial coefficient mod prime block.
// Holds field widths, the microcode step codes and the control/status structs.
// No dependencies.
package bcmp_pkg;

  localparam int unsigned MAX_N = 4194304;
  localparam int N_W = $clog2(MAX_N);
  localparam int M_W = 31;
  localparam int BIT_W = $clog2(M_W);
  localparam int PC_W = 4;
  localparam logic [M_W-1:0] MODULUS_RESET = 31'd1000000007;

  // Microcode step addresses
  typedef enum logic [PC_W-1:0] {
    P_IDLE,
    P_CAP,
    P_INC,
    P_FMUL,
    P_DEN,
    P_PINIT,
    P_SQR,
    P_TST,
    P_MULD,
    P_NXT,
    P_FIN,
    P_OUT
  } step_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INIT,
    ACT_CAPTURE,
    ACT_INC,
    ACT_POW_INIT,
    ACT_BIT_DEC,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_F_BY_I,
    MUL_FK_BY_FNK,
    MUL_ACC_SQ,
    MUL_ACC_BY_DEN,
    MUL_F_BY_ACC
  } mul_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_START,
    C_I_EQ_N,
    C_I_ZERO,
    C_EBIT_CLR,
    C_BIT_MORE,
    C_EMIT
  } cond_t;

  typedef struct packed {
    act_t  act;
    mul_t  mul;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    act_t act;
    logic act_en;
    mul_t mul;
    logic mul_start;
    logic mul_wb;
  } ctrl_t;

  typedef struct packed {
    logic special;
    logic i_eq_n;
    logic i_zero;
    logic ebit;
    logic bit_zero;
    logic mul_done;
  } stat_t;

endpackage

// ----- hw/rtl/bcmp_in_if.sv -----
// Input channel: one word carries the pair n, k.
// Depends on bcmp_pkg.
interface bcmp_in_if import bcmp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [N_W-1:0] n;
  logic [N_W-1:0] k;

  modport source (output valid, n, k, input ready);
  modport sink (input valid, n, k, output ready);
endinterface

// ----- hw/rtl/bcmp_out_if.sv -----
// Result channel: one word carries the coefficient and the k > n flag.
// Depends on bcmp_pkg.
interface bcmp_out_if import bcmp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [M_W-1:0] result;
  logic           k_exceeds_n;

  modport source (output valid, result, k_exceeds_n, input ready);
  modport sink (input valid, result, k_exceeds_n, output ready);
endinterface

// ----- hw/rtl/bcmp_cfg_if.sv -----
// Configuration write channel: one word carries the prime modulus.
// Depends on bcmp_pkg.
interface bcmp_cfg_if import bcmp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [M_W-1:0] modulus;

  modport source (output valid, modulus, input ready);
  modport sink (input valid, modulus, output ready);
endinterface

// ----- hw/rtl/binomial_coefficient_mod_prime.sv -----
// Binomial coefficient C(n,k) mod p, p from the configuration register (reset 1000000007).
// All products go through the bit-serial modular multiplier: one factorial product per i
// from 2 to n, up to 62 for the power p-2, and two more. k > n or p < 2 skips straight to
// the output word. One item in flight at a time.
// Reset: synchronous active low; clears the sequencer and output valid, loads the modulus.
module binomial_coefficient_mod_prime import bcmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bcmp_in_if.sink    in_ch,
  bcmp_out_if.source out_ch,
  bcmp_cfg_if.sink   cfg_ch
);

  logic [M_W-1:0] modulus_r, modulus_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [M_W-1:0] out_result_r, out_result_nxt;
  logic           out_flag_r, out_flag_nxt;
  logic           out_free;
  logic           emit;
  ctrl_t          ctrl;
  stat_t          stat;
  logic [M_W-1:0] dp_res;
  logic           dp_flag;

  assign out_free = !out_valid_r || out_ch.ready;
  assign emit     = (ctrl.act == ACT_EMIT) && ctrl.act_en;

  bcmp_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .ctrl     (ctrl)
  );

  bcmp_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_n        (in_ch.n),
    .in_k        (in_ch.k),
    .modulus     (modulus_r),
    .stat        (stat),
    .res         (dp_res),
    .k_exceeds_n (dp_flag)
  );

  always_comb begin
    modulus_nxt    = cfg_ch.valid ? cfg_ch.modulus : modulus_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    out_flag_nxt   = out_flag_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = dp_res;
      out_flag_nxt   = dp_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    out_flag_r   <= out_flag_nxt;
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result      = out_result_r;
  assign out_ch.k_exceeds_n = out_flag_r;

  a_flag_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flag_r) |-> (out_result_r == '0))
    else $error("k > n word carries a nonzero result");

  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result written over an untaken word");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second word accepted before the first finished");

endmodule

// ----- hw/rtl/bcmp_modmul.sv -----
// Bit-serial modular multiplier: p = a * b mod m, one bit of b per cycle, MSB first.
// Operand a must be below m. Depends on bcmp_pkg.
module bcmp_modmul import bcmp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [M_W-1:0] a,
  input  logic [M_W-1:0] b,
  input  logic [M_W-1:0] m,
  output logic           done,
  output logic [M_W-1:0] p
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BIT_W-1:0] cnt_r, cnt_nxt;
  logic [M_W-1:0]   a_r, a_nxt;
  logic [M_W-1:0]   b_r, b_nxt;
  logic [M_W-1:0]   acc_r, acc_nxt;
  logic [M_W:0]     dbl, dbl_red, sum, sum_red;

  always_comb begin
    // acc = (2*acc + bit*a) mod m, both reductions need at most one subtract
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = dbl_red + (b_r[M_W-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = BIT_W'(M_W - 1);
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = sum_red[M_W-1:0];
      b_nxt   = {b_r[M_W-2:0], 1'b0};
      cnt_nxt = cnt_r - BIT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiply issued while the unit is busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("multiply done while still iterating");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == '0) |=> done_r)
    else $error("last iteration not followed by done");

endmodule

// ----- hw/rtl/bcmp_datapath.sv -----
// Datapath: factorial registers, exponent bit counter and the shared modular multiplier.
// Driven by the sequencer control word. Depends on bcmp_pkg and bcmp_modmul.
module bcmp_datapath import bcmp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  ctrl_t          ctrl,
  input  logic [N_W-1:0] in_n,
  input  logic [N_W-1:0] in_k,
  input  logic [M_W-1:0] modulus,
  output stat_t          stat,
  output logic [M_W-1:0] res,
  output logic           k_exceeds_n
);

  logic [N_W-1:0]   n_r, k_r, nk_r, i_r;
  logic [M_W-1:0]   im_r, f_r, fk_r, fnk_r, den_r, acc_r, res_r;
  logic             flag_r;
  logic [BIT_W-1:0] bit_r;
  logic [M_W-1:0]   im_inc, expo;
  logic [M_W-1:0]   mul_a, mul_b, mul_p;
  logic             mul_done;

  assign im_inc = im_r + M_W'(1);
  assign expo   = modulus - M_W'(2);

  always_comb begin
    case (ctrl.mul)
      MUL_F_BY_I: begin
        mul_a = f_r;
        mul_b = im_r;
      end
      MUL_FK_BY_FNK: begin
        mul_a = fk_r;
        mul_b = fnk_r;
      end
      MUL_ACC_SQ: begin
        mul_a = acc_r;
        mul_b = acc_r;
      end
      MUL_ACC_BY_DEN: begin
        mul_a = acc_r;
        mul_b = den_r;
      end
      MUL_F_BY_ACC: begin
        mul_a = f_r;
        mul_b = acc_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bcmp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (modulus),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (ctrl.act_en) begin
      case (ctrl.act)
        ACT_INIT: begin
          n_r    <= in_n;
          k_r    <= in_k;
          nk_r   <= in_n - in_k;
          i_r    <= '0;
          im_r   <= '0;
          f_r    <= M_W'(1);
          fk_r   <= M_W'(1);
          fnk_r  <= M_W'(1);
          res_r  <= '0;
          flag_r <= (in_k > in_n);
        end
        ACT_CAPTURE: begin
          if (i_r == k_r) fk_r <= f_r;
          if (i_r == nk_r) fnk_r <= f_r;
        end
        ACT_INC: begin
          i_r  <= i_r + N_W'(1);
          // running i mod m, wraps when it reaches the modulus
          im_r <= (im_inc == modulus) ? '0 : im_inc;
        end
        ACT_POW_INIT: begin
          acc_r <= M_W'(1);
          bit_r <= BIT_W'(M_W - 1);
        end
        ACT_BIT_DEC: begin
          bit_r <= bit_r - BIT_W'(1);
        end
        default: ;
      endcase
    end
    if (ctrl.mul_wb) begin
      case (ctrl.mul)
        MUL_F_BY_I:     f_r   <= mul_p;
        MUL_FK_BY_FNK:  den_r <= mul_p;
        MUL_ACC_SQ:     acc_r <= mul_p;
        MUL_ACC_BY_DEN: acc_r <= mul_p;
        MUL_F_BY_ACC:   res_r <= mul_p;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.special  = (in_k > in_n) || (modulus < M_W'(2));
    stat.i_eq_n   = (i_r == n_r);
    stat.i_zero   = (i_r == '0);
    stat.ebit     = expo[bit_r];
    stat.bit_zero = (bit_r == '0);
    stat.mul_done = mul_done;
  end

  assign res         = res_r;
  assign k_exceeds_n = flag_r;

endmodule

// ----- hw/rtl/bcmp_sequencer.sv -----
// Microcode sequencer: step counter, control word table and branch conditions.
// Emits one control word per cycle to the datapath. Depends on bcmp_pkg.
module bcmp_sequencer import bcmp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_free,
  input  stat_t stat,
  output logic  in_ready,
  output ctrl_t ctrl
);

  step_t  pc_r, pc_nxt;
  logic   wait_r, wait_nxt;
  ucode_t uc;
  logic   go;
  logic   take_jump;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      P_IDLE:  w = '{ACT_INIT,     MUL_NONE,       C_START,    P_OUT};
      P_CAP:   w = '{ACT_CAPTURE,  MUL_NONE,       C_I_EQ_N,   P_DEN};
      P_INC:   w = '{ACT_INC,      MUL_NONE,       C_I_ZERO,   P_CAP};
      P_FMUL:  w = '{ACT_NONE,     MUL_F_BY_I,     C_JUMP,     P_CAP};
      P_DEN:   w = '{ACT_NONE,     MUL_FK_BY_FNK,  C_NEXT,     P_PINIT};
      P_PINIT: w = '{ACT_POW_INIT, MUL_NONE,       C_NEXT,     P_SQR};
      P_SQR:   w = '{ACT_NONE,     MUL_ACC_SQ,     C_NEXT,     P_TST};
      P_TST:   w = '{ACT_NONE,     MUL_NONE,       C_EBIT_CLR, P_NXT};
      P_MULD:  w = '{ACT_NONE,     MUL_ACC_BY_DEN, C_NEXT,     P_NXT};
      P_NXT:   w = '{ACT_BIT_DEC,  MUL_NONE,       C_BIT_MORE, P_SQR};
      P_FIN:   w = '{ACT_NONE,     MUL_F_BY_ACC,   C_NEXT,     P_OUT};
      P_OUT:   w = '{ACT_EMIT,     MUL_NONE,       C_EMIT,     P_IDLE};
      default: w = '{ACT_NONE,     MUL_NONE,       C_JUMP,     P_IDLE};
    endcase
    return w;
  endfunction

  always_comb begin
    uc             = ucode_rom(pc_r);
    ctrl.act       = uc.act;
    ctrl.mul       = uc.mul;
    ctrl.act_en    = 1'b1;
    ctrl.mul_start = 1'b0;
    ctrl.mul_wb    = 1'b0;
    wait_nxt       = wait_r;
    go             = 1'b1;
    take_jump      = 1'b0;

    if (uc.mul != MUL_NONE) begin
      // issue once, then hold the step until the product comes back
      ctrl.mul_start = !wait_r;
      go             = wait_r && stat.mul_done;
      ctrl.mul_wb    = go;
      take_jump      = (uc.cond == C_JUMP);
      if (!wait_r) wait_nxt = 1'b1;
      else if (go) wait_nxt = 1'b0;
    end else begin
      case (uc.cond)
        C_NEXT:     take_jump = 1'b0;
        C_JUMP:     take_jump = 1'b1;
        C_START: begin
          go          = in_valid;
          ctrl.act_en = in_valid;
          take_jump   = stat.special;
        end
        C_I_EQ_N:   take_jump = stat.i_eq_n;
        C_I_ZERO:   take_jump = stat.i_zero;
        C_EBIT_CLR: take_jump = !stat.ebit;
        C_BIT_MORE: take_jump = !stat.bit_zero;
        C_EMIT: begin
          go          = out_free;
          ctrl.act_en = out_free;
          take_jump   = 1'b1;
        end
        default:    take_jump = 1'b1;
      endcase
    end

    if (!go) pc_nxt = pc_r;
    else if (take_jump) pc_nxt = uc.target;
    else pc_nxt = step_t'(PC_W'(pc_r) + PC_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= P_IDLE;
      wait_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      wait_r <= wait_nxt;
    end
  end

  assign in_ready = (pc_r == P_IDLE);

  a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == P_IDLE) |-> !wait_r)
    else $error("idle with a multiply still outstanding");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    stat.mul_done |-> wait_r)
    else $error("product returned with no multiply outstanding");

  a_wait_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r && !stat.mul_done) |=> $stable(pc_r))
    else $error("step advanced before the product returned");

endmodule
